>>> rtl/plrm_pkg.sv
// Shared constants, command and status types for the packet loss rate monitor.
// Used by the channel interfaces, the controller, the datapath and the checker.
package plrm_pkg;

  localparam int unsigned SEQ_W      = 32;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned CFG_W      = 32;
  localparam int unsigned RATIO_W    = 17;
  localparam int unsigned Q_BITS     = 16;
  localparam int unsigned BIN_W      = 5;
  localparam int unsigned MAX_BURST  = 16;
  localparam int unsigned HIST_DEPTH = MAX_BURST + 1;
  localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);
  localparam int unsigned DIV_CW     = $clog2(Q_BITS);
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEQ     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REORDER_WIN = 2'd2;

  localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = 32'd1000;
  localparam logic [CFG_W-1:0] MAX_SEQ_RST     = 32'd65535;
  localparam logic [CFG_W-1:0] REORDER_WIN_RST = 32'd10000;

  localparam logic [CNT_W-1:0]   CNT_MAX    = {CNT_W{1'b1}};
  localparam logic [RATIO_W-1:0] RATIO_FULL = {1'b1, {Q_BITS{1'b0}}};

  // Commands from the controller to the datapath, one per step of an item.
  typedef struct packed {
    logic load_in;
    logic classify;
    logic resolve;
    logic update;
    logic hist_wr;
    logic close_chk;
    logic close_apply;
    logic ratio_set;
    logic div_step;
    logic out_load;
  } plrm_cmd_t;

  typedef struct packed {
    logic in_action;
    logic close_ge;
    logic div_go;
    logic div_last;
  } plrm_stat_t;

endpackage

>>> rtl/plrm_ifs.sv
// Valid/ready channel interfaces for the request and result items.
// Depends on plrm_pkg for the field widths.
interface plrm_in_if import plrm_pkg::*;;
  logic               valid;
  logic               ready;
  logic               action;
  logic [SEQ_W-1:0]   seq;
  logic [BIN_W-1:0]   bin_index;

  modport source (output valid, action, seq, bin_index, input ready);
  modport sink   (input valid, action, seq, bin_index, output ready);
endinterface

interface plrm_out_if import plrm_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CNT_W-1:0]   lost_here;
  logic               was_reordered;
  logic               was_wrap_gap;
  logic               window_closed;
  logic [RATIO_W-1:0] loss_ratio_q16;
  logic [CNT_W-1:0]   measurements;
  logic [CNT_W-1:0]   reorder_total;
  logic [CNT_W-1:0]   bin_count;

  modport source (output valid, lost_here, was_reordered, was_wrap_gap, window_closed,
                  loss_ratio_q16, measurements, reorder_total, bin_count, input ready);
  modport sink   (input valid, lost_here, was_reordered, was_wrap_gap, window_closed,
                  loss_ratio_q16, measurements, reorder_total, bin_count, output ready);
endinterface

>>> rtl/plrm_ctrl.sv
// Sequencing state machine of the packet loss rate monitor.
// Depends on plrm_pkg for the command and status structs.
module plrm_ctrl import plrm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  plrm_stat_t stat_i,
  output plrm_cmd_t  cmd_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CLASS = 4'd1;
  localparam logic [3:0] ST_LOSS  = 4'd2;
  localparam logic [3:0] ST_UPD   = 4'd3;
  localparam logic [3:0] ST_HWR   = 4'd4;
  localparam logic [3:0] ST_CLOSE = 4'd5;
  localparam logic [3:0] ST_ADJ   = 4'd6;
  localparam logic [3:0] ST_RAT   = 4'd7;
  localparam logic [3:0] ST_DIV   = 4'd8;
  localparam logic [3:0] ST_RD    = 4'd9;
  localparam logic [3:0] ST_FIN   = 4'd10;

  logic [3:0] state_q, state_d;
  logic       out_vld_q, out_vld_d;
  logic       out_free;

  assign out_free    = !out_vld_q || out_ready_i;
  assign out_valid_o = out_vld_q;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = stat_i.in_action ? ST_RD : ST_CLASS;
        end
      end
      ST_CLASS: begin
        cmd_o.classify = 1'b1;
        state_d        = ST_LOSS;
      end
      ST_LOSS: begin
        cmd_o.resolve = 1'b1;
        state_d       = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = ST_HWR;
      end
      ST_HWR: begin
        cmd_o.hist_wr = 1'b1;
        state_d       = ST_CLOSE;
      end
      ST_CLOSE: begin
        cmd_o.close_chk = 1'b1;
        state_d         = stat_i.close_ge ? ST_ADJ : ST_FIN;
      end
      ST_ADJ: begin
        cmd_o.close_apply = 1'b1;
        state_d           = ST_RAT;
      end
      ST_RAT: begin
        cmd_o.ratio_set = 1'b1;
        state_d         = stat_i.div_go ? ST_DIV : ST_FIN;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_FIN;
        end
      end
      ST_RD: begin
        // The histogram read data is registered during this cycle.
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.out_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

>>> rtl/plrm_dp.sv
// Datapath of the packet loss rate monitor: registers, burst histogram,
// window accounting and the bit-serial ratio divider. Depends on plrm_pkg.
module plrm_dp import plrm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 action_i,
  input  logic [SEQ_W-1:0]     seq_i,
  input  logic [BIN_W-1:0]     bin_index_i,
  input  plrm_cmd_t            cmd_i,
  output plrm_stat_t           stat_o,
  output logic [CNT_W-1:0]     lost_here_o,
  output logic                 was_reordered_o,
  output logic                 was_wrap_gap_o,
  output logic                 window_closed_o,
  output logic [RATIO_W-1:0]   loss_ratio_q16_o,
  output logic [CNT_W-1:0]     measurements_o,
  output logic [CNT_W-1:0]     reorder_total_o,
  output logic [CNT_W-1:0]     bin_count_o
);

  // Configuration
  logic [CFG_W-1:0] win_size_q, max_seq_q, reorder_q;

  // Architectural state
  logic [SEQ_W-1:0]   last_seq_q;
  logic [CNT_W-1:0]   win_cnt_q, win_loss_q;
  logic               first_q;
  logic [RATIO_W-1:0] ratio_q;
  logic [CNT_W-1:0]   meas_q, late_tot_q;

  // Per-item working registers
  logic               act_q;
  logic [SEQ_W-1:0]   seq_q;
  logic [BIN_W-1:0]   bin_q;
  logic               inorder_q, gt_q;
  logic [SEQ_W-1:0]   back_q, gapl_q;
  logic [CNT_W-1:0]   lost_q;
  logic               late_q, wrap_q, closed_q, hist_hit_q;
  logic [CNT_W-1:0]   excess_q, adj_q;
  logic [CNT_W-1:0]   rem_q;
  logic [Q_BITS-1:0]  quo_q;
  logic [DIV_CW-1:0]  dcnt_q;

  // Histogram memory with reset-cleared valid bits
  logic [CNT_W-1:0]      hist_mem [HIST_DEPTH];
  logic [HIST_DEPTH-1:0] hist_vld_q;
  logic [CNT_W-1:0]      rd_data_q;
  logic                  rd_vld_q;
  logic [BIN_W-1:0]      rd_addr;
  logic                  rd_ok;
  logic [HIST_AW-1:0]    rd_idx;
  logic [HIST_AW-1:0]    wr_idx;
  logic [CNT_W-1:0]      rd_eff;
  logic [CNT_W-1:0]      hist_inc;

  // Combinational helpers
  logic               late_c, wrap_c, gap_c;
  logic [CNT_W-1:0]   wrap_lost;
  logic [CNT_W+1:0]   cnt_sum;
  logic [CNT_W:0]     loss_sum;
  logic [CNT_W:0]     rem2, rem_sub;
  logic               div_ge;
  logic [CNT_W-1:0]   rem_d;
  logic [Q_BITS-1:0]  quo_d;

  assign rd_addr  = act_q ? bin_q : lost_q[BIN_W-1:0];
  assign rd_ok    = act_q ? (bin_q <= BIN_W'(MAX_BURST)) : hist_hit_q;
  assign rd_idx   = rd_ok ? rd_addr[HIST_AW-1:0] : '0;
  assign wr_idx   = lost_q[HIST_AW-1:0];
  assign rd_eff   = rd_vld_q ? rd_data_q : '0;
  assign hist_inc = (rd_eff == CNT_MAX) ? CNT_MAX : rd_eff + CNT_W'(1);

  assign late_c    = !inorder_q && !gt_q && (back_q < reorder_q);
  assign wrap_c    = !inorder_q && !gt_q && !(back_q < reorder_q);
  assign gap_c     = !inorder_q && gt_q;
  assign wrap_lost = (back_q <= max_seq_q) ? max_seq_q - back_q : '0;

  assign cnt_sum  = {2'b00, win_cnt_q} + {2'b00, lost_q} + (CNT_W+2)'(1);
  assign loss_sum = {1'b0, win_loss_q} + {1'b0, lost_q};

  // One quotient bit per cycle; the remainder always stays below the window size.
  assign rem2    = {rem_q, 1'b0};
  assign rem_sub = rem2 - {1'b0, win_size_q};
  assign div_ge  = rem2 >= {1'b0, win_size_q};
  assign rem_d   = div_ge ? rem_sub[CNT_W-1:0] : rem2[CNT_W-1:0];
  assign quo_d   = {quo_q[Q_BITS-2:0], div_ge};

  assign stat_o.in_action = action_i;
  assign stat_o.close_ge  = win_cnt_q >= win_size_q;
  assign stat_o.div_go    = (win_size_q != '0) && (adj_q < win_size_q);
  assign stat_o.div_last  = dcnt_q == DIV_CW'(Q_BITS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_size_q <= WINDOW_SIZE_RST;
      max_seq_q  <= MAX_SEQ_RST;
      reorder_q  <= REORDER_WIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WINDOW_SIZE: win_size_q <= cfg_wdata_i;
        CFG_MAX_SEQ:     max_seq_q  <= cfg_wdata_i;
        CFG_REORDER_WIN: reorder_q  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_seq_q <= '0;
      win_cnt_q  <= '0;
      win_loss_q <= '0;
      first_q    <= 1'b1;
      ratio_q    <= '0;
      meas_q     <= '0;
      late_tot_q <= '0;
      hist_vld_q <= '0;
      dcnt_q     <= '0;
    end else begin
      if (cmd_i.update) begin
        if (late_q) begin
          late_tot_q <= late_tot_q + CNT_W'(1);
          // A saturated count first stays at the top, then loses the late packet.
          win_cnt_q  <= (win_cnt_q == CNT_MAX) ? CNT_MAX - CNT_W'(1) : win_cnt_q;
        end else begin
          last_seq_q <= seq_q;
          win_cnt_q  <= (cnt_sum[CNT_W+1:CNT_W] != 2'b00) ? CNT_MAX : cnt_sum[CNT_W-1:0];
          win_loss_q <= loss_sum[CNT_W] ? CNT_MAX : loss_sum[CNT_W-1:0];
        end
      end
      if (cmd_i.hist_wr && hist_hit_q) begin
        hist_vld_q[wr_idx] <= 1'b1;
      end
      if (cmd_i.close_apply) begin
        win_cnt_q  <= excess_q;
        win_loss_q <= excess_q;
        meas_q     <= meas_q + CNT_W'(1);
        first_q    <= 1'b0;
      end
      if (cmd_i.ratio_set) begin
        if (win_size_q == '0) begin
          if (adj_q != '0) begin
            ratio_q <= RATIO_FULL;
          end
        end else if (adj_q >= win_size_q) begin
          ratio_q <= RATIO_FULL;
        end
        dcnt_q <= '0;
      end
      if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q + DIV_CW'(1);
        if (stat_o.div_last) begin
          ratio_q <= {1'b0, quo_d};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hist_wr && hist_hit_q) begin
      hist_mem[wr_idx] <= hist_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_ok && hist_vld_q[rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= hist_mem[rd_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q      <= 1'b0;
      lost_q     <= '0;
      late_q     <= 1'b0;
      wrap_q     <= 1'b0;
      closed_q   <= 1'b0;
      hist_hit_q <= 1'b0;
    end else begin
      if (cmd_i.load_in) begin
        act_q      <= action_i;
        lost_q     <= '0;
        late_q     <= 1'b0;
        wrap_q     <= 1'b0;
        closed_q   <= 1'b0;
        hist_hit_q <= 1'b0;
      end
      if (cmd_i.resolve) begin
        late_q     <= late_c;
        wrap_q     <= wrap_c;
        hist_hit_q <= gap_c && (gapl_q <= CNT_W'(MAX_BURST));
        lost_q     <= gap_c ? gapl_q : (wrap_c ? wrap_lost : '0);
      end
      if (cmd_i.close_chk) begin
        closed_q <= stat_o.close_ge;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      seq_q <= seq_i;
      bin_q <= bin_index_i;
    end
    if (cmd_i.classify) begin
      inorder_q <= ({1'b0, seq_q} == ({1'b0, last_seq_q} + (SEQ_W+1)'(1))) || first_q ||
                   (last_seq_q == max_seq_q) || (seq_q == '0);
      gt_q      <= seq_q > last_seq_q;
      back_q    <= last_seq_q - seq_q;
      // seq - last - 1 equals seq + ~last in modular arithmetic.
      gapl_q    <= seq_q + ~last_seq_q;
    end
    if (cmd_i.close_chk) begin
      excess_q <= win_cnt_q - win_size_q;
    end
    if (cmd_i.close_apply) begin
      adj_q <= (win_loss_q > excess_q) ? win_loss_q - excess_q : '0;
    end
    if (cmd_i.ratio_set) begin
      rem_q <= adj_q;
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
    if (cmd_i.out_load) begin
      lost_here_o      <= lost_q;
      was_reordered_o  <= late_q;
      was_wrap_gap_o   <= wrap_q;
      window_closed_o  <= closed_q;
      loss_ratio_q16_o <= ratio_q;
      measurements_o   <= meas_q;
      reorder_total_o  <= late_tot_q;
      bin_count_o      <= act_q ? rd_eff : '0;
    end
  end

endmodule

>>> rtl/packet_loss_rate_monitor_core.sv
// Packet loss rate monitor top level: controller, datapath and channel wiring.
// A packet steps through classify, resolve, update, histogram write and window check;
// a closing window adds the adjust and ratio steps and, unless the ratio saturates or
// the size is zero, the 16-step divider; a read only reads the histogram. One item is
// in flight at a time; the next can be accepted in the cycle after the result is loaded.
// Reset (rst_ni, asynchronous, active low) clears all counters and the histogram.
module packet_loss_rate_monitor_core import plrm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  plrm_in_if.sink              in_i,
  plrm_out_if.source           out_o
);

  plrm_cmd_t  cmd;
  plrm_stat_t stat;

  plrm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  plrm_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .action_i         (in_i.action),
    .seq_i            (in_i.seq),
    .bin_index_i      (in_i.bin_index),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .lost_here_o      (out_o.lost_here),
    .was_reordered_o  (out_o.was_reordered),
    .was_wrap_gap_o   (out_o.was_wrap_gap),
    .window_closed_o  (out_o.window_closed),
    .loss_ratio_q16_o (out_o.loss_ratio_q16),
    .measurements_o   (out_o.measurements),
    .reorder_total_o  (out_o.reorder_total),
    .bin_count_o      (out_o.bin_count)
  );

endmodule

>>> rtl/plrm_checker.sv
// Port-level assertions for the packet loss rate monitor and their bind.
// Depends on plrm_pkg; attaches to packet_loss_rate_monitor_core.
module plrm_checker import plrm_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [CNT_W-1:0]   lost_here,
  input logic               was_reordered,
  input logic               was_wrap_gap,
  input logic               window_closed,
  input logic [RATIO_W-1:0] loss_ratio_q16,
  input logic [CNT_W-1:0]   bin_count
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(lost_here) && $stable(bin_count) &&
    $stable(loss_ratio_q16) && $stable(window_closed))
    else $error("stalled result changed");

  // Only one request is worked on at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in progress");

  a_class_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !(was_reordered && was_wrap_gap) && (loss_ratio_q16 <= RATIO_FULL))
    else $error("conflicting classification or ratio out of range");

  a_late_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && was_reordered |-> lost_here == '0)
    else $error("late packet reported losses");

  // A histogram count only appears on a read, which reports no packet fields.
  a_read_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (bin_count != '0) |-> (lost_here == '0) && !window_closed &&
    !was_reordered && !was_wrap_gap)
    else $error("read result carries packet fields");

endmodule

bind packet_loss_rate_monitor_core plrm_checker u_plrm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid       (in_i.valid),
  .in_ready       (in_i.ready),
  .out_valid      (out_o.valid),
  .out_ready      (out_o.ready),
  .lost_here      (out_o.lost_here),
  .was_reordered  (out_o.was_reordered),
  .was_wrap_gap   (out_o.was_wrap_gap),
  .window_closed  (out_o.window_closed),
  .loss_ratio_q16 (out_o.loss_ratio_q16),
  .bin_count      (out_o.bin_count)
);

>>> tb/tb_top.sv
// Self-checking testbench for packet_loss_rate_monitor_core: drives packet and bin read
// requests, predicts every result with a scoreboard class and checks them field by field.
// Depends on plrm_pkg and the channel interfaces plrm_in_if and plrm_out_if.
module tb_top import plrm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit ACT_PACKET = 1'b0;
  localparam bit ACT_READ   = 1'b1;

  typedef struct {
    bit               action;
    bit [SEQ_W-1:0]   seq;
    bit [BIN_W-1:0]   bin_index;
  } plrm_req_t;

  typedef struct {
    bit [CNT_W-1:0]   lost_here;
    bit               was_reordered;
    bit               was_wrap_gap;
    bit               window_closed;
    bit [RATIO_W-1:0] loss_ratio_q16;
    bit [CNT_W-1:0]   measurements;
    bit [CNT_W-1:0]   reorder_total;
    bit [CNT_W-1:0]   bin_count;
  } plrm_res_t;

  class loss_scoreboard;
    bit [CFG_W-1:0]   win_size;
    bit [CFG_W-1:0]   seq_limit;
    bit [CFG_W-1:0]   late_span;
    bit [SEQ_W-1:0]   last_seq;
    bit [CNT_W-1:0]   win_count;
    bit [CNT_W-1:0]   win_losses;
    bit               first_win;
    bit [RATIO_W-1:0] ratio;
    bit [CNT_W-1:0]   measures;
    bit [CNT_W-1:0]   late_count;
    bit [CNT_W-1:0]   burst_bins [HIST_DEPTH];
    plrm_res_t        expected_q [$];
    int unsigned      errors;
    int unsigned      n_packets, n_reads, n_gaps, n_late, n_wraps, n_closed;

    function new();
      win_size   = WINDOW_SIZE_RST;
      seq_limit  = MAX_SEQ_RST;
      late_span  = REORDER_WIN_RST;
      last_seq   = '0;
      win_count  = '0;
      win_losses = '0;
      first_win  = 1'b1;
      ratio      = '0;
      measures   = '0;
      late_count = '0;
      foreach (burst_bins[i]) burst_bins[i] = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_WINDOW_SIZE: win_size = val;
        CFG_MAX_SEQ:     seq_limit = val;
        CFG_REORDER_WIN: late_span = val;
        default: ;
      endcase
    endfunction

    function bit [CNT_W-1:0] sat_add(bit [CNT_W-1:0] a, bit [CNT_W-1:0] b);
      bit [CNT_W:0] s;
      s = a + b;
      return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

    // The excess over the window size is carried into the next window as both
    // counted packets and losses.
    function bit close_window();
      bit [CNT_W-1:0] excess;
      bit [47:0]      q;
      excess = '0;
      if (win_count < win_size) return 1'b0;
      first_win = 1'b0;
      if (win_count > win_size) begin
        excess     = win_count - win_size;
        win_count  = win_size;
        win_losses = (win_losses > excess) ? win_losses - excess : '0;
      end
      if (win_count != '0) begin
        q = {win_losses, 16'h0000} / {16'h0000, win_count};
        ratio = (q > 48'd65536) ? RATIO_FULL : q[RATIO_W-1:0];
      end else if (win_losses != '0) begin
        ratio = RATIO_FULL;
      end
      measures++;
      win_count  = excess;
      win_losses = excess;
      return 1'b1;
    endfunction

    function void note_request(plrm_req_t rq);
      plrm_res_t      r;
      bit [SEQ_W-1:0] prev;
      bit [SEQ_W-1:0] back;
      bit [CNT_W-1:0] lost;
      r = '{default: '0};
      lost = '0;
      if (rq.action == ACT_READ) begin
        n_reads++;
        if (rq.bin_index <= MAX_BURST) r.bin_count = burst_bins[rq.bin_index];
      end else begin
        n_packets++;
        prev = last_seq;
        win_count = sat_add(win_count, 1);
        if (({1'b0, rq.seq} != {1'b0, prev} + 33'd1) && !first_win &&
            prev != seq_limit && rq.seq != '0) begin
          if (rq.seq > prev) begin
            lost = rq.seq - prev - 1;
            n_gaps++;
            if (lost <= MAX_BURST) burst_bins[lost] = sat_add(burst_bins[lost], 1);
            win_losses = sat_add(win_losses, lost);
            win_count  = sat_add(win_count, lost);
            last_seq   = rq.seq;
          end else if (prev - rq.seq < late_span) begin
            r.was_reordered = 1'b1;
            n_late++;
            late_count++;
            win_count = (win_count > 0) ? win_count - 1 : '0;
          end else begin
            // A backward jump too far to be late is taken as a wrap past max_seq.
            back = prev - rq.seq;
            r.was_wrap_gap = 1'b1;
            n_wraps++;
            lost = (back <= seq_limit) ? seq_limit - back : '0;
            win_losses = sat_add(win_losses, lost);
            win_count  = sat_add(win_count, lost);
            last_seq   = rq.seq;
          end
        end else begin
          last_seq = rq.seq;
        end
        r.lost_here     = lost;
        r.window_closed = close_window();
        if (r.window_closed) n_closed++;
      end
      r.loss_ratio_q16 = ratio;
      r.measurements   = measures;
      r.reorder_total  = late_count;
      expected_q.push_back(r);
    endfunction

    function void flag_failure(string msg);
      errors++;
      if (errors <= 10) $display("[%0t] MISMATCH: %s", $time, msg);
    endfunction

    function void compare(string field, bit [31:0] want, bit [31:0] got);
      if (want != got)
        flag_failure($sformatf("%s expected 0x%0h got 0x%0h", field, want, got));
    endfunction

    function void check_result(plrm_res_t got);
      plrm_res_t want;
      if (expected_q.size() == 0) begin
        flag_failure("result arrived with no request outstanding");
        return;
      end
      want = expected_q.pop_front();
      compare("lost_here",      want.lost_here,      got.lost_here);
      compare("was_reordered",  want.was_reordered,  got.was_reordered);
      compare("was_wrap_gap",   want.was_wrap_gap,   got.was_wrap_gap);
      compare("window_closed",  want.window_closed,  got.window_closed);
      compare("loss_ratio_q16", want.loss_ratio_q16, got.loss_ratio_q16);
      compare("measurements",   want.measurements,   got.measurements);
      compare("reorder_total",  want.reorder_total,  got.reorder_total);
      compare("bin_count",      want.bin_count,      got.bin_count);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  plrm_in_if  in_if ();
  plrm_out_if out_if ();

  packet_loss_rate_monitor_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  loss_scoreboard sb;
  int unsigned    burst_left;
  bit [SEQ_W-1:0] gen_seq;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("** packet_loss_rate_monitor_core: FAILED **");
    $finish;
  end

  // Result side stalls on its own pattern, periodically picking a new mode at random.
  initial begin
    int unsigned cyc;
    int unsigned rx_mode;
    cyc = 0;
    rx_mode = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc % 64 == 0) rx_mode = $urandom_range(0, 2);
      case (rx_mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= ($urandom_range(0, 9) < 7);
        default: out_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready)
      sb.note_request(plrm_req_t'{in_if.action, in_if.seq, in_if.bin_index});
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_result(plrm_res_t'{out_if.lost_here, out_if.was_reordered,
                                  out_if.was_wrap_gap, out_if.window_closed,
                                  out_if.loss_ratio_q16, out_if.measurements,
                                  out_if.reorder_total, out_if.bin_count});
  end

  // Presents one request; the sender works in bursts with idle gaps between them.
  task automatic send_request(bit act, bit [SEQ_W-1:0] s, bit [BIN_W-1:0] b);
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    in_if.valid     <= 1'b1;
    in_if.action    <= act;
    in_if.seq       <= s;
    in_if.bin_index <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic packet(bit [SEQ_W-1:0] s);
    send_request(ACT_PACKET, s, BIN_W'($urandom));
  endtask

  task automatic read_bin(bit [BIN_W-1:0] b);
    send_request(ACT_READ, $urandom, b);
  endtask

  // Holds the sender back until every outstanding request has its result.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(bit [CFG_W-1:0] ws, bit [CFG_W-1:0] ms, bit [CFG_W-1:0] rw);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_WINDOW_SIZE;
    cfg_wdata_i <= ws;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_MAX_SEQ;
    cfg_wdata_i <= ms;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_REORDER_WIN;
    cfg_wdata_i <= rw;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_reg(CFG_WINDOW_SIZE, ws);
    sb.set_reg(CFG_MAX_SEQ, ms);
    sb.set_reg(CFG_REORDER_WIN, rw);
  endtask

  // Mostly well-formed streams (in order, short gaps, late copies, wraps) plus noise.
  task automatic run_traffic(int unsigned n, bit [CFG_W-1:0] max_s, bit [CFG_W-1:0] span);
    int unsigned    pick;
    int unsigned    back_lim;
    bit [SEQ_W-1:0] s;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        read_bin(BIN_W'($urandom_range(0, (pick < 8) ? 16 : 31)));
      end else begin
        if (pick < 58) begin
          s = (gen_seq >= max_s) ? '0 : gen_seq + 1;
        end else if (pick < 72) begin
          s = gen_seq + 2 + $urandom_range(0, (pick < 70) ? 16 : 3000);
        end else if (pick < 84) begin
          back_lim = (span > 20) ? 20 : span;
          s = gen_seq - $urandom_range(0, back_lim + 1);
        end else if (pick < 92) begin
          s = $urandom_range(0, (max_s < 40) ? max_s : 40);
        end else begin
          s = $urandom;
        end
        if (pick < 72 || pick >= 84) gen_seq = s;
        packet(s);
      end
    end
  endtask

  initial begin
    bit [CFG_W-1:0] ws, ms, rw;
    sb = new();
    burst_left  = 0;
    gen_seq     = '0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_WINDOW_SIZE;
    cfg_wdata_i = '0;
    in_if.valid     = 1'b0;
    in_if.action    = ACT_PACKET;
    in_if.seq       = '0;
    in_if.bin_index = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: the first window is still open, so nothing is a gap yet.
    packet(0);
    packet(5);
    read_bin(0);
    drain();

    // One-packet windows; the first close has more excess than losses.
    set_config(1, 100, 3);
    packet(10);
    packet(11);
    packet(14);
    packet(31);
    packet(49);
    packet(48);
    packet(49);
    packet(40);
    packet(100);
    packet(3);
    packet(0);
    packet(5000);
    packet(7);
    read_bin(2);
    read_bin(16);
    read_bin(17);
    read_bin(31);
    drain();

    // Widest settings: huge gaps and a duplicate taken as a full wrap saturate the count.
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    packet(1);
    packet(32'hFFFF_FFFE);
    packet(1);
    packet(1);
    drain();

    // Zero-sized windows close on every packet; every backward step is late.
    set_config(0, 1, 32'hFFFF_FFFF);
    packet(0);
    packet(3);
    packet(2);
    read_bin(1);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin ws = 8; ms = 200; rw = 16; end
        1: begin
          ws = $urandom_range(1, 40);
          ms = $urandom_range(20, 500);
          rw = $urandom_range(0, 30);
        end
        2: begin ws = 1; ms = 1; rw = 32'hFFFF_FFFF; end
        3: begin ws = WINDOW_SIZE_RST; ms = MAX_SEQ_RST; rw = REORDER_WIN_RST; end
        default: begin
          ws = $urandom_range(2, 100);
          ms = 32'hFFFF_FFFF;
          rw = $urandom_range(0, 12);
        end
      endcase
      set_config(ws, ms, rw);
      run_traffic(215, ms, rw);
      drain();
    end

    repeat (30) @(posedge clk_i);
    sb.errors += sb.pending();
    $display("Run covered %0d packet requests (%0d gaps, %0d late, %0d wrap gaps)",
             sb.n_packets, sb.n_gaps, sb.n_late, sb.n_wraps);
    $display("and %0d bin reads, with %0d windows closed across eight register settings; %0d failures counted.",
             sb.n_reads, sb.n_closed, sb.errors);
    if (sb.errors == 0) begin
      $display("** packet_loss_rate_monitor_core: PASSED **");
    end else begin
      $display("** packet_loss_rate_monitor_core: FAILED **");
    end
    $finish;
  end

endmodule
